/* sv/eks_pkg.sv */
// Shared types and constants for the Epanechnikov kernel smoother.
package eks_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS = 16;
   localparam int HALF_WIDTH_BITS = 4;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] HALF_WIDTH_ADDR = 2'd0;
   localparam logic [HALF_WIDTH_BITS-1:0] HALF_WIDTH_RESET = 4'd2;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic last;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] smoothed;
      logic last_out;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_TAP   = 5'b00010,
      S_DRAIN = 5'b00100,
      S_DIV   = 5'b01000,
      S_EMIT  = 5'b10000
   } eks_state_type;

   typedef enum logic [1:0] {
      SEL_MEM   = 2'b00,
      SEL_FIRST = 2'b01,
      SEL_LAST  = 2'b10
   } eks_sel_type;

endpackage

/* sv/eks_div.sv */
// Restoring divider, one quotient bit per cycle.
module eks_div import eks_pkg::*; #(
   parameter int DEN_BITS = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [DEN_BITS+SAMPLE_BITS-1:0] num,
   input  logic [DEN_BITS-1:0]             den,
   output logic                            done,
   output logic [SAMPLE_BITS-1:0]          quot
);

   localparam int NUMB = DEN_BITS + SAMPLE_BITS;
   localparam int CNTB = $clog2(SAMPLE_BITS);

   logic            busy_ff;
   logic            done_ff;
   logic [CNTB-1:0] cnt_ff;
   logic [NUMB-1:0] rem_ff;
   logic [NUMB-1:0] dv_ff;
   logic [SAMPLE_BITS-1:0] q_ff;
   logic            ge;
   logic [NUMB-1:0] diff;

   assign ge = rem_ff >= dv_ff;
   assign diff = rem_ff - dv_ff;
   assign done = done_ff;
   assign quot = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CNTB'(SAMPLE_BITS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         // divisor aligned to the top quotient bit
         dv_ff <= {1'b0, den, {(SAMPLE_BITS-1){1'b0}}};
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= diff;
         end
         q_ff <= {q_ff[SAMPLE_BITS-2:0], ge};
         dv_ff <= dv_ff >> 1;
      end
   end

endmodule

/* sv/epanechnikov_kernel_smoother.sv */
// Streaming Epanechnikov kernel smoother over a ring memory of recent samples.
// The req channel takes one sample (Q8.8) with a last flag; the rsp channel
// returns smoothed samples. Output k leaves once sample k+W has arrived,
// W being the half_width register (byte address 0, reset 2). The item that
// carries last flushes every pending output, the final one with last_out set.
// Each output runs its 2W+1 taps through the ring read port and a
// multiply-accumulate pipe, drains the pipe, runs the serial division
// and loads the result register; an item with no output is taken
// without a stall, and a last item runs those steps once per flushed
// output.
// req_stall is high while an item is in work. The result register parts the
// two sides: a new item is taken while a result still waits, and when the
// receiver stalls the next result waits in the divider until the register
// frees. Reset returns the sequence count to zero; ring contents need no
// clearing, since only samples of the current sequence are read.
module epanechnikov_kernel_smoother import eks_pkg::*; #(
   parameter int MAX_HALF_WIDTH = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH + 1;
   localparam int PW = $clog2(RING_DEPTH);
   localparam int HWB = $clog2(MAX_HALF_WIDTH + 1);
   localparam int JB = HWB + 1;
   localparam int LB = HWB + 1;
   localparam int WTB = 2 * LB;
   localparam int DENB = WTB + PW;
   localparam int NUMB = DENB + SAMPLE_BITS;
   localparam int PRODB = WTB + SAMPLE_BITS;
   localparam int MB = COUNT_BITS + 2;

   eks_state_type state_ff;
   logic [HALF_WIDTH_BITS-1:0] hw_ff;
   logic [HWB-1:0] w_cfg;
   logic [PW-1:0] wr_ff;
   logic [PW-1:0] wr_next;
   logic [COUNT_BITS-1:0] count_ff;
   logic [SAMPLE_BITS-1:0] first_ff;

   logic [COUNT_BITS-1:0] n_ff;
   logic [COUNT_BITS-1:0] k_ff;
   logic [HWB-1:0] w_ff;
   logic clip_ff;
   logic [SAMPLE_BITS-1:0] firstuse_ff;
   logic [SAMPLE_BITS-1:0] newest_ff;
   logic signed [JB-1:0] j_ff;

   logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_ff;
   eks_sel_type sel1_ff;
   logic [WTB-1:0] wt1_ff;
   logic v1_ff;
   logic [PRODB-1:0] prod_ff;
   logic [WTB-1:0] wt2_ff;
   logic v2_ff;
   logic [NUMB-1:0] num_ff;
   logic [DENB-1:0] den_ff;

   rsp_type rsp_ff;
   logic rspv_ff;

   logic req_acc;
   logic has_out;
   logic [COUNT_BITS-1:0] k_start;
   logic signed [MB-1:0] m_s;
   logic neg;
   logic over;
   logic [MB-1:0] back_full;
   logic [PW-1:0] back;
   logic [JB-1:0] negj;
   logic [HWB-1:0] absj;
   logic [COUNT_BITS-1:0] nk;
   logic [HWB-1:0] d;
   logic [LB-1:0] len;
   logic [WTB-1:0] wt;
   logic [PW:0] addr_wrap;
   logic [PW-1:0] addr;
   eks_sel_type sel;
   logic issue;
   logic [SAMPLE_BITS-1:0] y;
   logic div_start;
   logic div_done;
   logic [SAMPLE_BITS-1:0] quot;
   logic emit_load;
   logic more;
   logic acc_clr;
   logic csr_wr;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr == HALF_WIDTH_ADDR);
   assign csr_prdata = (csr_paddr == HALF_WIDTH_ADDR) ?
                       CSR_DATA_BITS'(hw_ff) : '0;

   always_comb begin
      if (HWB'(MAX_HALF_WIDTH) < hw_ff) begin
         w_cfg = HWB'(MAX_HALF_WIDTH);
      end else begin
         w_cfg = HWB'(hw_ff);
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc = req_valid && !req_stall;
   assign wr_next = (wr_ff == PW'(RING_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign has_out = req_data.last || (count_ff >= COUNT_BITS'(w_cfg));
   assign k_start = (count_ff >= COUNT_BITS'(w_cfg)) ?
                    count_ff - COUNT_BITS'(w_cfg) : '0;

   // tap address and weight
   assign m_s = $signed({2'b00, k_ff}) + {{(MB-JB){j_ff[JB-1]}}, j_ff};
   assign neg = m_s[MB-1];
   assign over = clip_ff && (m_s > $signed({2'b00, n_ff}));
   assign back_full = {2'b00, n_ff} - m_s;
   assign back = back_full[PW-1:0];
   assign negj = JB'(0) - j_ff;
   assign absj = j_ff[JB-1] ? negj[HWB-1:0] : j_ff[HWB-1:0];
   assign nk = n_ff - k_ff;
   assign len = {w_ff, 1'b1};

   always_comb begin
      if (neg) begin
         d = k_ff[HWB-1:0];
         sel = SEL_FIRST;
      end else if (over) begin
         d = nk[HWB-1:0];
         sel = SEL_LAST;
      end else begin
         d = absj;
         sel = SEL_MEM;
      end
   end

   assign wt = WTB'(len) * WTB'(len) - WTB'(d) * WTB'(d);
   assign addr_wrap = (PW+1)'(wr_ff) + (PW+1)'(RING_DEPTH) - (PW+1)'(back);
   assign addr = (wr_ff >= back) ? wr_ff - back : addr_wrap[PW-1:0];
   assign issue = (state_ff == S_TAP);

   always_comb begin
      case (sel1_ff)
         SEL_FIRST: y = firstuse_ff;
         SEL_LAST:  y = newest_ff;
         default:   y = rd_ff;
      endcase
   end

   assign div_start = (state_ff == S_DRAIN) && !v1_ff && !v2_ff;
   assign emit_load = (state_ff == S_EMIT) && (!rspv_ff || !rsp_stall);
   assign more = clip_ff && (k_ff != n_ff);
   assign acc_clr = (req_acc && has_out) || (emit_load && more);

   // ring memory
   always_ff @(posedge clock) begin
      if (req_acc) begin
         ring[wr_next] <= req_data.sample;
      end
      if (issue) begin
         rd_ff <= ring[addr];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hw_ff <= HALF_WIDTH_RESET;
         wr_ff <= '0;
         count_ff <= '0;
         first_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rspv_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            hw_ff <= csr_pwdata[HALF_WIDTH_BITS-1:0];
         end
         v1_ff <= issue;
         v2_ff <= v1_ff;
         if (emit_load) begin
            rspv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rspv_ff <= 1'b0;
         end
         if (req_acc) begin
            wr_ff <= wr_next;
            if (req_data.last) begin
               count_ff <= '0;
               first_ff <= '0;
            end else begin
               if (count_ff == '0) begin
                  first_ff <= req_data.sample;
               end
               if (count_ff != '1) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc && has_out) begin
                  state_ff <= S_TAP;
               end
            end
            S_TAP: begin
               if (j_ff == $signed({1'b0, w_ff})) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (div_start) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit_load) begin
                  state_ff <= more ? S_TAP : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // item context, pipeline and accumulators
   always_ff @(posedge clock) begin
      if (req_acc) begin
         n_ff <= count_ff;
         w_ff <= w_cfg;
         clip_ff <= req_data.last;
         k_ff <= k_start;
         newest_ff <= req_data.sample;
         firstuse_ff <= (count_ff == '0) ? req_data.sample : first_ff;
      end else if (emit_load && more) begin
         k_ff <= k_ff + 1'b1;
      end
      if (acc_clr) begin
         j_ff <= JB'(0) - $signed({1'b0, (req_acc ? w_cfg : w_ff)});
      end else if (issue) begin
         j_ff <= j_ff + 1'b1;
      end
      sel1_ff <= sel;
      wt1_ff <= wt;
      prod_ff <= PRODB'(wt1_ff) * PRODB'(y);
      wt2_ff <= wt1_ff;
      if (acc_clr) begin
         num_ff <= '0;
         den_ff <= '0;
      end else if (v2_ff) begin
         num_ff <= num_ff + NUMB'(prod_ff);
         den_ff <= den_ff + DENB'(wt2_ff);
      end
      if (emit_load) begin
         rsp_ff.smoothed <= quot;
         rsp_ff.last_out <= clip_ff && (k_ff == n_ff);
      end
   end

   eks_div #(
      .DEN_BITS(DENB)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(num_ff),
      .den(den_ff),
      .done(div_done),
      .quot(quot)
   );

   assign rsp_valid = rspv_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside division state");
   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff))
      else $error("accumulate stage without multiply stage");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!v1_ff && !v2_ff))
      else $error("tap pipe busy while idle");
   a_div_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (!v1_ff && !v2_ff))
      else $error("tap pipe busy during division");
`endif

endmodule

/* tb/sv/tb_epanechnikov_kernel_smoother.sv */
// Self-checking testbench for the Epanechnikov kernel smoother.
`timescale 1ns / 100ps

module tb_epanechnikov_kernel_smoother;
   import eks_pkg::*;

   localparam int RING_DEPTH = 31;
   localparam int MAX_HW = 15;
   localparam int COUNT_CAP = 65535;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 60;

   // Running kernel smoother with its own copy of state and the queue of smoothed samples due.
   class smooth_scoreboard;
      logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
      logic [SAMPLE_BITS-1:0] first_smp;
      int seq_count;
      int wr_pos;
      int half_width;
      rsp_type due_q[$];

      function new();
         foreach (ring[i]) ring[i] = '0;
         first_smp = '0;
         seq_count = 0;
         wr_pos = 0;
         half_width = HALF_WIDTH_RESET;
      endfunction

      function void set_half_width(logic [HALF_WIDTH_BITS-1:0] v);
         half_width = (v > MAX_HW) ? MAX_HW : int'(v);
      endfunction

      function logic [SAMPLE_BITS-1:0] kernel_avg(int k, int n, int w, bit clip);
         longint num, den, wt, y;
         int len, m, d;
         num = 0;
         den = 0;
         len = 2 * w + 1;
         for (int j = -w; j <= w; j++) begin
            m = k + j;
            if (m < 0) begin
               y = first_smp;
               d = k;
            end else if (clip && m > n) begin
               y = ring[wr_pos];
               d = n - k;
            end else begin
               y = ring[(wr_pos + RING_DEPTH - ((n - m) % RING_DEPTH)) % RING_DEPTH];
               d = (j < 0) ? -j : j;
            end
            wt = len * len - d * d;
            num += wt * y;
            den += wt;
         end
         return SAMPLE_BITS'(num / den);
      endfunction

      function void note_sample(req_type item);
         int n, w;
         rsp_type r;
         n = seq_count;
         w = half_width;
         if (n == 0) first_smp = item.sample;
         wr_pos = (wr_pos + 1) % RING_DEPTH;
         ring[wr_pos] = item.sample;
         if (seq_count < COUNT_CAP) seq_count++;
         if (item.last) begin
            for (int k = (n >= w) ? n - w : 0; k <= n; k++) begin
               r.smoothed = kernel_avg(k, n, w, 1'b1);
               r.last_out = (k == n);
               due_q.push_back(r);
            end
            seq_count = 0;
            first_smp = '0;
         end else if (n >= w) begin
            r.smoothed = kernel_avg(n - w, n, w, 1'b0);
            r.last_out = 1'b0;
            due_q.push_back(r);
         end
      endfunction

      // Returns an empty string when the item matches.
      function string check_result(rsp_type got);
         rsp_type want;
         if (due_q.size() == 0) return $sformatf("unexpected result %h", got);
         want = due_q.pop_front();
         if (got.smoothed !== want.smoothed)
            return $sformatf("smoothed %h, expected %h", got.smoothed, want.smoothed);
         if (got.last_out !== want.last_out)
            return $sformatf("last_out %b, expected %b", got.last_out, want.last_out);
         return "";
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   smooth_scoreboard sb;
   int err_count;
   int results_seen;
   int items_sent;
   int hold_asked;
   int hold_done;
   bit no_idle;
   int burst_left;

   epanechnikov_kernel_smoother i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   // Receiver: check accepted items, stall on a drifting pattern, honour long hold-offs.
   int stall_pct;
   int hold_left;
   int pat_cycle;
   always @(posedge clock) begin
      string msg;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         pat_cycle = 0;
         stall_pct = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            msg = sb.check_result(rsp_data);
            results_seen++;
            if (msg != "") report(msg);
         end
         pat_cycle++;
         if (pat_cycle % 97 == 0) stall_pct = $urandom_range(0, 3) * 25;
         if (hold_left == 0 && hold_done != hold_asked) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic send_item(logic [SAMPLE_BITS-1:0] smp, bit last);
      req_type item;
      int gap;
      item.sample = smp;
      item.last = last;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      sb.note_sample(item);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 12);
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == HALF_WIDTH_ADDR) sb.set_half_width(data[HALF_WIDTH_BITS-1:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(logic [CSR_ADDR_BITS-1:0] addr, logic [CSR_DATA_BITS-1:0] want);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[HALF_WIDTH_BITS-1:0] !== want[HALF_WIDTH_BITS-1:0])
         report($sformatf("register read %h, expected %h", csr_prdata, want));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return SAMPLE_BITS'($urandom_range(0, 15));
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // One sequence of random content; mostly short, now and then long.
   task automatic send_sequence(int len, bit close);
      for (int i = 0; i < len; i++) send_item(rand_sample(), close && (i == len - 1));
   endtask

   initial begin
      int hw_plan [7];
      int len;
      hw_plan = '{0, 15, 1, 7, 3, 15, 5};
      sb = new();
      err_count = 0;
      results_seen = 0;
      items_sent = 0;
      hold_asked = 0;
      hold_done = 0;
      no_idle = 1'b0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset width, extremes, single and two-sample sequences.
      csr_check(HALF_WIDTH_ADDR, HALF_WIDTH_RESET);
      send_item('0, 1'b1);
      send_item('1, 1'b1);
      send_item('1, 1'b0);
      send_item('0, 1'b1);
      for (int i = 0; i < 8; i++) send_item((i % 2) ? '1 : '0, i == 7);
      send_item(16'h0001, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'hffff, 1'b0);
      send_item(16'h5555, 1'b0);
      send_item(16'haaaa, 1'b0);
      send_item(16'h0100, 1'b1);
      wait_drained();

      foreach (hw_plan[p]) begin
         csr_write(HALF_WIDTH_ADDR, CSR_DATA_BITS'(hw_plan[p]));
         csr_check(HALF_WIDTH_ADDR, CSR_DATA_BITS'(hw_plan[p]));
         no_idle = (p % 3 == 2);
         if (p == 1) hold_asked++;
         for (int s = 0; s < 5; s++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            send_sequence(len, 1'b1);
            if (p == 3 && s == 2) wait_drained();
         end
         // Leave a sequence open across the next width change.
         if (p == 4) send_sequence($urandom_range(4, 10), 1'b0);
         wait_drained();
      end
      send_sequence(5, 1'b1);
      wait_drained();

      if (sb.pending() != 0) report($sformatf("%0d results never came", sb.pending()));
      $display("Ran %0d samples and %0d smoothed results over half widths 0 to 15,",
               items_sent, results_seen);
      $display("with open sequences across width changes and long receiver hold-offs.");
      if (err_count == 0) begin
         $display("tb_epanechnikov_kernel_smoother: clean");
      end else begin
         $display("tb_epanechnikov_kernel_smoother: errors");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("tb_epanechnikov_kernel_smoother: errors");
      $finish;
   end

endmodule
